### hw/rtl/tpt_pkg.sv
`timescale 1ns / 1ps
package tpt_pkg;

    localparam int NPHASE = 5;
    localparam int DIFF_W = 32;
    localparam int SUM_W  = 40;
    localparam int CORR_W = 46;
    localparam int THR_W  = 10;
    localparam int PROD_W = 56;

    typedef logic [2:0]              phase_t;
    typedef logic [SUM_W-1:0]        sum_t;
    typedef logic signed [CORR_W-1:0] corr_t;

    localparam phase_t PHASE_UNKNOWN = 3'd5;

    typedef enum logic [1:0] {
        REG_THRESHOLD  = 2'd0,
        REG_DEGHOST    = 2'd1,
        REG_WINDOW     = 2'd2,
        REG_INIT_PHASE = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ACT_DROP    = 2'd0,
        ACT_PASS    = 2'd1,
        ACT_DEGHOST = 2'd2
    } action_t;

    // Ranked correlation of one frame, handed to the output stage
    typedef struct packed {
        phase_t              pos;
        phase_t              best;
        corr_t               top;
        logic [CORR_W-1:0]   gap;
    } rank_t;

    localparam corr_t PLAIN_TAPS [NPHASE] = '{
        corr_t'(-4), corr_t'(1), corr_t'(1), corr_t'(1), corr_t'(1)
    };
    localparam corr_t GHOST_TAPS [NPHASE] = '{
        corr_t'(-2), corr_t'(-3), corr_t'(4), corr_t'(4), corr_t'(-3)
    };

    // (p + 4) mod 5
    function automatic phase_t prev_phase(input phase_t p);
        phase_t r;
        case (p)
            3'd0:    r = 3'd4;
            3'd1:    r = 3'd0;
            3'd2:    r = 3'd1;
            3'd3:    r = 3'd2;
            3'd4:    r = 3'd3;
            3'd5:    r = 3'd4;
            3'd6:    r = 3'd0;
            default: r = 3'd1;
        endcase
        return r;
    endfunction

    // (pos + 10 - ph) mod 5, for pos 0..4 and ph 0..5
    function automatic phase_t phase_offset(input phase_t pos, input phase_t ph);
        logic [3:0] v;
        v = 4'(pos) + 4'd10 - 4'(ph);
        if (v >= 4'd10) begin
            v = v - 4'd10;
        end else if (v >= 4'd5) begin
            v = v - 4'd5;
        end
        return phase_t'(v);
    endfunction

endpackage

### hw/rtl/tpt_hist.sv
`timescale 1ns / 1ps
module tpt_hist
    import tpt_pkg::*;
#(
    parameter int DEPTH = 80,
    parameter int AW    = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DIFF_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr,
    output logic [DIFF_W-1:0] rd_data
);

    logic [DIFF_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  vld_reg;
    logic [DIFF_W-1:0] rd_data_reg;
    logic              rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    // unwritten entries read as zero
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

### hw/rtl/tpt_rank.sv
`timescale 1ns / 1ps
module tpt_rank
    import tpt_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   deghost_en,
    input  logic   in_valid,
    output logic   in_ready,
    input  phase_t in_pos,
    input  sum_t   in_sums [NPHASE],
    output logic   out_valid,
    input  logic   out_ready,
    output rank_t  out_data
);

    corr_t  term [NPHASE][NPHASE];
    corr_t  corr [NPHASE];

    logic   b_valid_reg;
    phase_t b_pos_reg;
    corr_t  b_corr_reg [NPHASE];

    logic   c_valid_reg;
    phase_t c_pos_reg;
    corr_t  c_corr_reg [NPHASE];
    phase_t c_best_reg;
    corr_t  c_top_reg;

    logic   d_valid_reg;
    rank_t  d_data_reg;

    logic   b_ready;
    logic   c_ready;
    logic   d_ready;

    phase_t best_idx;
    corr_t  best_val;
    corr_t  second_val;
    logic   second_found;

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign in_ready = b_ready;

    // correlate the five sums against the pattern rotated to each phase
    for (genvar gf = 0; gf < NPHASE; gf++) begin : g_phase
        for (genvar gn = 0; gn < NPHASE; gn++) begin : g_slot
            localparam int K = (gn + NPHASE - gf) % NPHASE;
            corr_t slot_val;
            assign slot_val      = corr_t'(in_sums[gn]);
            assign term[gf][gn]  = deghost_en ? slot_val * GHOST_TAPS[K]
                                              : slot_val * PLAIN_TAPS[K];
        end
        assign corr[gf] = term[gf][0] + term[gf][1] + term[gf][2]
                        + term[gf][3] + term[gf][4];
    end

    // first maximum wins ties
    always_comb begin
        best_idx = '0;
        best_val = b_corr_reg[0];
        for (int n = 1; n < NPHASE; n++) begin
            if (b_corr_reg[n] > best_val) begin
                best_idx = phase_t'(n);
                best_val = b_corr_reg[n];
            end
        end
    end

    always_comb begin
        second_found = 1'b0;
        second_val   = '0;
        for (int n = 0; n < NPHASE; n++) begin
            if (phase_t'(n) != c_best_reg &&
                (!second_found || c_corr_reg[n] > second_val)) begin
                second_val   = c_corr_reg[n];
                second_found = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (b_ready) begin
                b_valid_reg <= in_valid;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_ready) begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready && in_valid) begin
            b_pos_reg  <= in_pos;
            b_corr_reg <= corr;
        end
        if (c_ready && b_valid_reg) begin
            c_pos_reg  <= b_pos_reg;
            c_corr_reg <= b_corr_reg;
            c_best_reg <= best_idx;
            c_top_reg  <= best_val;
        end
        if (d_ready && c_valid_reg) begin
            d_data_reg.pos  <= c_pos_reg;
            d_data_reg.best <= c_best_reg;
            d_data_reg.top  <= c_top_reg;
            d_data_reg.gap  <= c_top_reg - second_val;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_data  = d_data_reg;

    a_gap_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        d_valid_reg |-> !d_data_reg.gap[CORR_W-1])
        else $error("ranked gap is negative");

    a_best_range: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg |-> c_best_reg < phase_t'(NPHASE))
        else $error("best phase out of range");

    a_best_is_max: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg |-> (c_top_reg >= c_corr_reg[0]) && (c_top_reg >= c_corr_reg[1]) &&
                        (c_top_reg >= c_corr_reg[2]) && (c_top_reg >= c_corr_reg[3]) &&
                        (c_top_reg >= c_corr_reg[4]))
        else $error("best score below another phase");

endmodule

### hw/rtl/telecine_phase_tracker_top.sv
`timescale 1ns / 1ps
// Telecine phase tracker.
// Input channel (s_valid/s_ready, s_frame_diff): one frame-difference metric per
// frame. Result channel (m_valid/m_ready): action, phase in use, best phase and
// confidence flag, one result per input frame, in order.
// Configuration port (cfg_wr_en/cfg_addr/cfg_wdata): index 0 threshold (Q8),
// 1 deghost level, 2 window length in groups of five frames, 3 initial phase
// (loads the running phase at once). Write only while no frame is in flight.
// Pipeline: the phase sums update when a frame is accepted, then one stage each
// for the five-phase correlation, best-phase search, runner-up and gap, and the
// threshold multiply with the phase update into the output register.
// Throughput: one frame per cycle unless the result channel stalls; the history
// memory is read one frame ahead.
// Reset: phase sums, counters and history valid bits clear in the reset cycle,
// so a frame can be accepted right after reset; registers take their defaults.
// Stall: when m_ready is low the result holds and the pipeline stages fill up
// behind it; s_ready drops only once every stage holds a frame.
module telecine_phase_tracker_top
    import tpt_pkg::*;
#(
    parameter int MAX_WINDOW_GROUPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [9:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_frame_diff,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_action,
    output logic [2:0]  m_phase_now,
    output logic [2:0]  m_best_phase,
    output logic        m_confident
);

    localparam int HIST_DEPTH = NPHASE * MAX_WINDOW_GROUPS;
    localparam int WP_W       = $clog2(HIST_DEPTH);
    localparam int WIN_W      = $clog2(HIST_DEPTH + 1);
    localparam int GRP_RESET  = (MAX_WINDOW_GROUPS < 6) ? MAX_WINDOW_GROUPS : 6;
    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(NPHASE * GRP_RESET);

    // configuration
    logic [THR_W-1:0] thr_reg;
    logic             deghost_en_reg;
    logic [WIN_W-1:0] win_reg;
    logic [WIN_W-1:0] win_next;
    phase_t           cur_phase_reg;
    phase_t           cur_phase_next;
    logic [31:0]      grp_req;
    logic [31:0]      grp_clamped;
    logic [WIN_W-1:0] win_cfg;
    logic             cfg_thr_wr;
    logic             cfg_dg_wr;
    logic             cfg_win_wr;
    logic             cfg_ph_wr;

    // front state
    phase_t           pos_reg;
    logic [WP_W-1:0]  wp_reg;
    logic [WP_W-1:0]  wp_eff;
    logic [WIN_W-1:0] wp_inc;
    logic [WP_W-1:0]  wp_adv;
    logic [WP_W-1:0]  wp_next;
    logic [WP_W-1:0]  rd_addr;
    logic             seen_first_reg;
    sum_t             slot_sums_reg [NPHASE];
    sum_t             sum_upd;
    logic [DIFF_W-1:0] hist_rd;
    logic             accept;

    logic             a_valid_reg;
    phase_t           a_pos_reg;

    // rank and output stage
    logic             rank_in_ready;
    logic             rank_valid;
    rank_t            rank_data;
    logic             out_ready_int;
    logic             fire_out;
    logic             top_pos;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] gap_q8;
    logic             conf;
    phase_t           prop;
    logic             take;
    phase_t           phase_upd;
    phase_t           offs;
    action_t          act;

    logic             m_valid_reg;
    action_t          m_action_reg;
    phase_t           m_phase_reg;
    phase_t           m_best_reg;
    logic             m_conf_reg;

    // ---------------- configuration decode ----------------
    always_comb begin
        cfg_thr_wr = 1'b0;
        cfg_dg_wr  = 1'b0;
        cfg_win_wr = 1'b0;
        cfg_ph_wr  = 1'b0;
        unique case (reg_idx_t'(cfg_addr))
            REG_THRESHOLD:  cfg_thr_wr = cfg_wr_en;
            REG_DEGHOST:    cfg_dg_wr  = cfg_wr_en;
            REG_WINDOW:     cfg_win_wr = cfg_wr_en;
            REG_INIT_PHASE: cfg_ph_wr  = cfg_wr_en;
        endcase
    end

    always_comb begin
        grp_req = 32'(cfg_wdata[4:0]);
        if (grp_req == 32'd0) begin
            grp_clamped = 32'd1;
        end else if (grp_req > 32'(MAX_WINDOW_GROUPS)) begin
            grp_clamped = 32'(MAX_WINDOW_GROUPS);
        end else begin
            grp_clamped = grp_req;
        end
        win_cfg  = WIN_W'(grp_clamped * 32'(NPHASE));
        win_next = cfg_win_wr ? win_cfg : win_reg;
    end

    // ---------------- window position and history ----------------
    assign s_ready = !a_valid_reg || rank_in_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        wp_eff  = (WIN_W'(wp_reg) >= win_reg) ? '0 : wp_reg;
        wp_inc  = WIN_W'(wp_eff) + WIN_W'(1);
        wp_adv  = (wp_inc >= win_reg) ? '0 : WP_W'(wp_inc);
        wp_next = accept ? wp_adv : wp_reg;
        // prefetch the entry the next frame will take back out
        rd_addr = (WIN_W'(wp_next) >= win_next) ? '0 : wp_next;
    end

    tpt_hist #(
        .DEPTH (HIST_DEPTH),
        .AW    (WP_W)
    ) u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (accept && seen_first_reg),
        .wr_addr (wp_eff),
        .wr_data (s_frame_diff),
        .rd_addr (rd_addr),
        .rd_data (hist_rd)
    );

    assign sum_upd = slot_sums_reg[pos_reg] - SUM_W'(hist_rd) + SUM_W'(s_frame_diff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            wp_reg         <= '0;
            seen_first_reg <= 1'b0;
            a_valid_reg    <= 1'b0;
            for (int n = 0; n < NPHASE; n++) begin
                slot_sums_reg[n] <= '0;
            end
        end else begin
            wp_reg <= wp_next;
            if (accept) begin
                pos_reg        <= (pos_reg == phase_t'(NPHASE - 1)) ? '0 : pos_reg + 3'd1;
                seen_first_reg <= 1'b1;
                if (seen_first_reg) begin
                    slot_sums_reg[pos_reg] <= sum_upd;
                end
            end
            if (s_ready) begin
                a_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_pos_reg <= pos_reg;
        end
    end

    // ---------------- correlation and ranking ----------------
    tpt_rank u_rank (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .deghost_en (deghost_en_reg),
        .in_valid   (a_valid_reg),
        .in_ready   (rank_in_ready),
        .in_pos     (a_pos_reg),
        .in_sums    (slot_sums_reg),
        .out_valid  (rank_valid),
        .out_ready  (out_ready_int),
        .out_data   (rank_data)
    );

    // ---------------- confidence, phase update, action ----------------
    assign out_ready_int = !m_valid_reg || m_ready;
    assign fire_out      = rank_valid && out_ready_int;

    always_comb begin
        top_pos = !rank_data.top[CORR_W-1] && (rank_data.top != '0);
        prod    = PROD_W'(thr_reg) * {{(PROD_W-CORR_W){1'b0}}, rank_data.top};
        gap_q8  = {{(PROD_W-CORR_W-8){1'b0}}, rank_data.gap, 8'h00};
        conf    = top_pos ? (gap_q8 >= prod) : (thr_reg == '0);

        prop = conf ? rank_data.best : cur_phase_reg;
        // take over only if the drop point stays on the same side of this frame
        take = (prop != cur_phase_reg) &&
               ((prev_phase(cur_phase_reg) < rank_data.pos) ==
                (prev_phase(prop) < rank_data.pos));
        phase_upd = take ? prop : cur_phase_reg;

        offs = phase_offset(rank_data.pos, phase_upd);
        if (offs == 3'd0) begin
            act = ACT_DROP;
        end else if (offs == 3'd4 && deghost_en_reg) begin
            act = ACT_DEGHOST;
        end else begin
            act = ACT_PASS;
        end
    end

    always_comb begin
        cur_phase_next = cur_phase_reg;
        if (cfg_ph_wr) begin
            cur_phase_next = (cfg_wdata[2:0] > PHASE_UNKNOWN) ? PHASE_UNKNOWN : cfg_wdata[2:0];
        end else if (fire_out) begin
            cur_phase_next = phase_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg        <= THR_W'(128);
            deghost_en_reg <= 1'b0;
            win_reg        <= WIN_RESET;
            cur_phase_reg  <= PHASE_UNKNOWN;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_thr_wr) begin
                thr_reg <= cfg_wdata;
            end
            if (cfg_dg_wr) begin
                deghost_en_reg <= |cfg_wdata[7:0];
            end
            win_reg       <= win_next;
            cur_phase_reg <= cur_phase_next;
            if (out_ready_int) begin
                m_valid_reg <= rank_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire_out) begin
            m_action_reg <= act;
            m_phase_reg  <= phase_upd;
            m_best_reg   <= rank_data.best;
            m_conf_reg   <= conf;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_action     = m_action_reg;
    assign m_phase_now  = m_phase_reg;
    assign m_best_phase = m_best_reg;
    assign m_confident  = m_conf_reg;

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_phase_reg <= PHASE_UNKNOWN)
        else $error("running phase out of range");

    a_deghost_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_action_reg == ACT_DEGHOST) |-> deghost_en_reg)
        else $error("deghost action while deghosting is off");

    a_wp_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(accept) |-> (WIN_W'(wp_reg) < win_reg))
        else $error("window position past window after a frame");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg < phase_t'(NPHASE))
        else $error("group position out of range");

endmodule

### tb/telecine_phase_tracker_top_test.sv
`timescale 1ns / 1ps
module telecine_phase_tracker_top_test;
    import tpt_pkg::*;

    localparam int WIN_GROUPS_MAX = 16;
    localparam int HIST_LEN       = 5 * WIN_GROUPS_MAX;
    localparam int STALL_LIMIT    = 2000;
    localparam int LONG_HOLD      = 150;
    localparam int PRINT_CAP      = 40;

    typedef struct {
        action_t action;
        phase_t  phase_now;
        phase_t  best;
        logic    confident;
    } frame_verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [9:0]  cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_frame_diff = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_action;
    logic [2:0]  m_phase_now;
    logic [2:0]  m_best_phase;
    logic        m_confident;

    telecine_phase_tracker_top #(
        .MAX_WINDOW_GROUPS(WIN_GROUPS_MAX)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_frame_diff(s_frame_diff),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_action    (m_action),
        .m_phase_now (m_phase_now),
        .m_best_phase(m_best_phase),
        .m_confident (m_confident)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Tracker state mirrored on the testbench side
    logic [9:0]  thr_q8;
    logic [7:0]  deghost;
    logic [4:0]  win_groups;
    logic [2:0]  init_ph;
    int unsigned grp_pos;
    int unsigned hist_pos;
    bit          primed;
    logic [39:0] phase_sum [5];
    logic [31:0] diff_hist [HIST_LEN];
    int unsigned phase_cur;

    longint plain_tap [5] = '{-4, 1, 1, 1, 1};
    longint ghost_tap [5] = '{-2, -3, 4, 4, -3};

    logic [31:0]    frames_to_send [$];
    frame_verdict_t verdicts_due [$];

    bit          sending;
    bit          quiet;
    bit          want_long_hold;
    bit          progress;
    int          gap_left;
    int          stall_left;
    int          hold_left;
    int          idle_cycles;
    int          fail_count;
    int          frames_taken;
    int          results_seen;
    int          confident_seen;
    int          act_seen [3];
    int          mode_count;
    int unsigned gen_pos;

    function automatic int unsigned window_len();
        int unsigned g;
        g = win_groups;
        if (g < 1) g = 1;
        if (g > WIN_GROUPS_MAX) g = WIN_GROUPS_MAX;
        return 5 * g;
    endfunction

    function automatic frame_verdict_t track_frame(input logic [31:0] diff);
        int unsigned    win;
        int unsigned    pos;
        int unsigned    best;
        int unsigned    second;
        int unsigned    proposed;
        int unsigned    r;
        longint         corr [5];
        longint         acc;
        longint         tap;
        logic [63:0]    lhs;
        logic [63:0]    rhs;
        logic           conf;
        frame_verdict_t v;

        win = window_len();
        pos = grp_pos % 5;
        if (hist_pos >= win) hist_pos = 0;

        // the first frame after reset has no predecessor: skip the sums
        if (primed) begin
            phase_sum[pos] = phase_sum[pos] - {8'd0, diff_hist[hist_pos]} + {8'd0, diff};
            diff_hist[hist_pos] = diff;
        end else begin
            primed = 1'b1;
        end

        for (int f = 0; f < 5; f++) begin
            acc = 0;
            for (int n = 0; n < 5; n++) begin
                tap = (deghost != 0) ? ghost_tap[(n + 5 - f) % 5] : plain_tap[(n + 5 - f) % 5];
                acc += longint'({24'd0, phase_sum[n]}) * tap;
            end
            corr[f] = acc;
        end

        best = 0;
        for (int n = 1; n < 5; n++)
            if (corr[n] > corr[best]) best = n;
        second = (best != 0) ? 0 : 1;
        for (int n = second + 1; n < 5; n++)
            if (n != best && corr[n] > corr[second]) second = n;

        if (corr[best] > 0) begin
            lhs  = 64'(corr[best] - corr[second]) << 8;
            rhs  = {54'd0, thr_q8} * 64'(corr[best]);
            conf = (lhs >= rhs);
        end else begin
            conf = (thr_q8 == 0);
        end

        // take the new phase only if the drop point stays on the same side of pos
        proposed = conf ? best : phase_cur;
        if (proposed != phase_cur &&
            ((((phase_cur + 4) % 5) < pos) == (((proposed + 4) % 5) < pos)))
            phase_cur = proposed;

        r = (pos + 10 - phase_cur) % 5;
        if (r == 0) v.action = ACT_DROP;
        else if (r == 4 && deghost != 0) v.action = ACT_DEGHOST;
        else v.action = ACT_PASS;
        v.phase_now = phase_t'(phase_cur);
        v.best      = phase_t'(best);
        v.confident = conf;

        grp_pos  = (pos + 1) % 5;
        hist_pos = (hist_pos + 1 >= win) ? 0 : hist_pos + 1;
        return v;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        if (fail_count < PRINT_CAP)
            $display("mismatch: %s at result %0d: got %0d, want %0d",
                     what, results_seen, got, want);
        fail_count++;
    endtask

    // Acceptance on both channels, prediction and checking
    always @(posedge aclk) begin
        if (aresetn) begin
            progress = 1'b0;
            if (s_valid && s_ready) begin
                verdicts_due.push_back(track_frame(s_frame_diff));
                sending = 1'b0;
                frames_taken++;
                progress = 1'b1;
            end
            if (m_valid && m_ready) begin
                progress = 1'b1;
                if (verdicts_due.size() == 0) begin
                    flag_mismatch("unexpected result", m_action, 0);
                end else begin
                    frame_verdict_t w;
                    w = verdicts_due.pop_front();
                    if (m_action !== w.action) flag_mismatch("action", m_action, w.action);
                    if (m_phase_now !== w.phase_now)
                        flag_mismatch("phase_now", m_phase_now, w.phase_now);
                    if (m_best_phase !== w.best)
                        flag_mismatch("best_phase", m_best_phase, w.best);
                    if (m_confident !== w.confident)
                        flag_mismatch("confident", m_confident, w.confident);
                end
                if (m_action < 3) act_seen[m_action]++;
                if (m_confident === 1'b1) confident_seen++;
                results_seen++;
            end
            if (progress) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
                $display("telecine_phase_tracker_top_test failed");
                $finish;
            end
        end
    end

    // Frame sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!sending) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (frames_to_send.size() != 0 && !quiet && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(0, 12);
                s_valid <= 1'b0;
            end else if (frames_to_send.size() != 0) begin
                s_frame_diff <= frames_to_send.pop_front();
                s_valid <= 1'b1;
                sending = 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (want_long_hold) begin
                want_long_hold = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 12);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_frame(input logic [31:0] d);
        frames_to_send.push_back(d);
        gen_pos = (gen_pos + 1) % 5;
    endtask

    // 3:2 cadence: low metric on the repeated field slots, phase jumps when asked
    task automatic push_cadence(input int n, input int unsigned ph, input bit ghostly,
                                input int jump_every);
        logic [31:0] mag;
        int unsigned off;
        bit          high;
        mag = 32'd1 << $urandom_range(3, 30);
        mag = mag + ($urandom & (mag - 1));
        for (int i = 0; i < n; i++) begin
            if (jump_every > 0 && (i % jump_every) == jump_every - 1)
                ph = $urandom_range(0, 4);
            off  = (gen_pos + 5 - ph) % 5;
            high = ghostly ? (off == 2 || off == 3) : (off != 0);
            if (high) push_frame(mag + $urandom_range(0, mag >> 3));
            else push_frame($urandom_range(0, mag >> 4));
        end
    endtask

    task automatic push_noise(input int n);
        int unsigned k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 9);
            if (k < 5) push_frame($urandom);
            else if (k < 8) push_frame($urandom_range(0, 255));
            else if (k == 8) push_frame(32'hFFFF_FFFF);
            else push_frame(32'd0);
        end
    endtask

    task automatic push_random(input int n);
        int count;
        int len;
        int unsigned k;
        count = 0;
        while (count < n) begin
            k = $urandom_range(0, 99);
            if (k < 70) begin
                len = $urandom_range(20, 100);
                push_cadence(len, $urandom_range(0, 4),
                             (deghost != 0) ^ ($urandom_range(0, 5) == 0), 0);
            end else if (k < 85) begin
                len = $urandom_range(1, 25);
                push_noise(len);
            end else begin
                len = $urandom_range(20, 60);
                push_cadence(len, $urandom_range(0, 4), $urandom_range(0, 1),
                             $urandom_range(3, 9));
            end
            count += len;
        end
    endtask

    task automatic wait_drained();
        while (frames_to_send.size() != 0 || sending || verdicts_due.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [9:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_THRESHOLD:  thr_q8     = val;
            REG_DEGHOST:    deghost    = val[7:0];
            REG_WINDOW:     win_groups = val[4:0];
            REG_INIT_PHASE: begin
                init_ph   = val[2:0];
                phase_cur = (init_ph > PHASE_UNKNOWN) ? PHASE_UNKNOWN : init_ph;
            end
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_mode(input logic [9:0] thr, input logic [9:0] deg,
                            input logic [9:0] win, input logic [9:0] ph);
        wait_drained();
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_DEGHOST, deg);
        write_reg(REG_WINDOW, win);
        write_reg(REG_INIT_PHASE, ph);
        mode_count++;
    endtask

    initial begin
        thr_q8     = 10'd128;
        deghost    = 8'd0;
        win_groups = 5'd6;
        init_ph    = 3'd5;
        phase_cur  = PHASE_UNKNOWN;
        grp_pos    = 0;
        hist_pos   = 0;
        primed     = 1'b0;
        for (int i = 0; i < 5; i++) phase_sum[i] = '0;
        for (int i = 0; i < HIST_LEN; i++) diff_hist[i] = '0;
        gen_pos    = 0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // defaults: extremes of the metric, then a clean plain cadence
        push_frame(32'd0);
        push_frame(32'hFFFF_FFFF);
        push_frame(32'hFFFF_FFFF);
        push_frame(32'd0);
        push_frame(32'h8000_0000);
        push_frame(32'd1);
        push_cadence(15, 2, 1'b0, 0);

        // zero threshold, ghost pattern, window 0 acts as 1, phase 7 loads unknown
        set_mode(10'd0, 10'd255, 10'd0, 10'd7);
        push_cadence(10, 1, 1'b1, 0);
        push_random(150);

        // strict threshold, oversized window clamps, phase 6 loads unknown
        set_mode(10'd512, 10'd0, 10'd31, 10'd6);
        push_random(200);
        want_long_hold = 1'b1;

        // deghost value with only bits above the field set stays off
        set_mode(10'd1023, 10'h300, 10'd16, 10'd0);
        push_random(150);

        set_mode(10'd200, 10'd1, 10'd1, 10'd3);
        push_random(200);

        set_mode(10'd64, 10'd0, 10'd17, 10'd5);
        push_random(200);

        for (int p = 0; p < 3; p++) begin
            set_mode($urandom_range(0, 600), $urandom_range(0, 1023),
                     $urandom_range(0, 31), $urandom_range(0, 7));
            push_random(200);
        end

        // last stretch without any idling
        set_mode($urandom_range(0, 300), $urandom_range(0, 3),
                 $urandom_range(1, 8), $urandom_range(0, 5));
        quiet = 1'b1;
        push_random(200);

        while (frames_to_send.size() != 0 || sending || verdicts_due.size() != 0)
            @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (verdicts_due.size() != 0)
            flag_mismatch("missing results", 0, verdicts_due.size());

        $display("ran %0d frames over %0d register settings, %0d results checked",
                 frames_taken, mode_count + 1, results_seen);
        $display("actions drop/pass/deghost %0d/%0d/%0d, confident %0d, mismatches %0d",
                 act_seen[0], act_seen[1], act_seen[2], confident_seen, fail_count);
        if (fail_count == 0) begin
            $display("telecine_phase_tracker_top_test passed");
        end else begin
            $display("telecine_phase_tracker_top_test failed");
        end
        $finish;
    end

endmodule
